>>> rtl/core/sha224_pkg.sv
package sha224_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 7;
    localparam int HASH_WORDS   = 8;
    localparam int ROUNDS       = 64;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_vars;

    localparam t_word HashInit [HASH_WORDS] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam t_word RoundK [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

>>> rtl/core/sha224_block_hash.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_message_word, i_start_message, i_final_block
// digest    out        o_valid / i_stall  o_digest_word, o_digest_index, o_last_digest_word
//
// A block takes 16 word transactions, one per cycle, then 64 rounds of the shared
// round unit (one round per cycle) and a fold into the hash state (S_ADD). A final
// block adds 7 digest transactions. o_stall is high from the 16th word until the
// digest has drained, or for a non-final block until the fold is done.
// Synchronous active-low reset loads the initial hash and clears the sequencer.
module sha224_block_hash
    import sha224_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_start_message,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_last_digest_word
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    localparam logic [3:0] LastWord  = 4'(BLOCK_WORDS - 1);
    localparam logic [5:0] LastRound = 6'(ROUNDS - 1);
    localparam logic [2:0] LastIdx   = 3'(DIGEST_WORDS - 1);

    t_state      r_state;
    logic [3:0]  r_count;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_final;
    logic        r_valid;
    logic        r_last;
    t_word       r_out_word;
    t_word       r_hash [HASH_WORDS];
    t_word       r_w [BLOCK_WORDS];
    t_vars       r_vars;

    t_vars       n_vars;
    t_word       n_w;
    t_vars       hash_vars;
    logic        in_acc;
    logic        out_acc;
    logic [3:0]  n_count;
    logic        n_final;

    sha224_round u_round (
        .i_vars   (r_vars),
        .i_k      (RoundK[r_round]),
        .i_w0     (r_w[0]),
        .i_w1     (r_w[1]),
        .i_w9     (r_w[9]),
        .i_w14    (r_w[14]),
        .o_vars   (n_vars),
        .o_w_next (n_w)
    );

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_valid && !i_stall;
    assign n_count = i_start_message ? 4'd0 : r_count;
    assign n_final = (i_start_message ? 1'b0 : r_final) | i_final_block;

    assign hash_vars = '{a: r_hash[0], b: r_hash[1], c: r_hash[2], d: r_hash[3],
                         e: r_hash[4], f: r_hash[5], g: r_hash[6], h: r_hash[7]};

    assign o_stall            = (r_state != S_LOAD);
    assign o_valid            = r_valid;
    assign o_digest_word      = r_out_word;
    assign o_digest_index     = r_idx;
    assign o_last_digest_word = r_last;

    // schedule window: shift line, new word enters at the top tap
    always_ff @(posedge i_clk) begin
        if (in_acc || r_state == S_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= in_acc ? i_message_word : n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_final <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= HashInit[i];
            end
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_start_message) begin
                            for (int i = 0; i < HASH_WORDS; i++) begin
                                r_hash[i] <= HashInit[i];
                            end
                        end
                        r_final <= n_final;
                        if (n_count == LastWord) begin
                            r_count <= '0;
                            r_round <= '0;
                            r_vars  <= hash_vars;
                            r_state <= S_ROUND;
                        end else begin
                            r_count <= n_count + 4'd1;
                        end
                    end
                end
                S_ROUND: begin
                    r_vars  <= n_vars;
                    r_round <= r_round + 6'd1;
                    if (r_round == LastRound) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_hash[0] <= r_hash[0] + r_vars.a;
                    r_hash[1] <= r_hash[1] + r_vars.b;
                    r_hash[2] <= r_hash[2] + r_vars.c;
                    r_hash[3] <= r_hash[3] + r_vars.d;
                    r_hash[4] <= r_hash[4] + r_vars.e;
                    r_hash[5] <= r_hash[5] + r_vars.f;
                    r_hash[6] <= r_hash[6] + r_vars.g;
                    r_hash[7] <= r_hash[7] + r_vars.h;
                    r_final   <= 1'b0;
                    if (r_final) begin
                        r_out_word <= r_hash[0] + r_vars.a;
                        r_idx      <= '0;
                        r_last     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_idx == LastIdx) begin
                            r_valid <= 1'b0;
                            r_last  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx      <= r_idx + 3'd1;
                            r_out_word <= r_hash[r_idx + 3'd1];
                            r_last     <= ((r_idx + 3'd1) == LastIdx);
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    a_no_input_while_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest pending");

    a_last_ends_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_digest_word) |=> !o_valid)
        else $error("digest run did not end after last word");

    a_last_at_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_digest_word) |-> (o_digest_index == LastIdx))
        else $error("last marker at wrong digest index");

    a_rounds_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == LastRound) |=> (r_state == S_ADD))
        else $error("round sequencer did not finish after last round");

endmodule

>>> rtl/core/sha224_round.sv
module sha224_round
    import sha224_pkg::*;
(
    input  t_vars i_vars,
    input  t_word i_k,
    input  t_word i_w0,
    input  t_word i_w1,
    input  t_word i_w9,
    input  t_word i_w14,
    output t_vars o_vars,
    output t_word o_w_next
);

    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    assign ch  = (i_vars.e & i_vars.f) ^ (~i_vars.e & i_vars.g);
    assign maj = (i_vars.a & i_vars.b) ^ (i_vars.a & i_vars.c) ^ (i_vars.b & i_vars.c);
    assign t1  = i_vars.h + big_sigma1(i_vars.e) + ch + i_k + i_w0;
    assign t2  = big_sigma0(i_vars.a) + maj;

    always_comb begin
        o_vars.h = i_vars.g;
        o_vars.g = i_vars.f;
        o_vars.f = i_vars.e;
        o_vars.e = i_vars.d + t1;
        o_vars.d = i_vars.c;
        o_vars.c = i_vars.b;
        o_vars.b = i_vars.a;
        o_vars.a = t1 + t2;
    end

    // W[t+16] from the window taps W[t], W[t+1], W[t+9], W[t+14]
    assign o_w_next = small_sigma1(i_w14) + i_w9 + small_sigma0(i_w1) + i_w0;

endmodule

>>> verif/sha224_block_hash_test.sv
typedef struct {
    sha224_pkg::t_word word;
    logic [2:0]        index;
    logic              last;
} t_digest_rec;

class sha224_digest_model;
    sha224_pkg::t_word chain_value [8];
    sha224_pkg::t_word sched [16];
    int unsigned       words_in_block;
    bit                final_seen;
    t_digest_rec       expected_digest [$];
    int                errors;
    int                checked;
    int                digests_predicted;

    function new();
        for (int i = 0; i < 8; i++) begin
            chain_value[i] = sha224_pkg::HashInit[i];
        end
        for (int i = 0; i < 16; i++) begin
            sched[i] = '0;
        end
        words_in_block = 0;
        final_seen = 1'b0;
        errors = 0;
        checked = 0;
        digests_predicted = 0;
    endfunction

    function sha224_pkg::t_word ror(input sha224_pkg::t_word v, input int unsigned n);
        logic [63:0] twice;
        twice = {v, v} >> n;
        return twice[31:0];
    endfunction

    function sha224_pkg::t_word sum0(input sha224_pkg::t_word v);
        return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function sha224_pkg::t_word sum1(input sha224_pkg::t_word v);
        return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function sha224_pkg::t_word sched_mix0(input sha224_pkg::t_word v);
        return ror(v, 7) ^ ror(v, 18) ^ {3'b000, v[31:3]};
    endfunction

    function sha224_pkg::t_word sched_mix1(input sha224_pkg::t_word v);
        return ror(v, 17) ^ ror(v, 19) ^ {10'd0, v[31:10]};
    endfunction

    function void compress();
        sha224_pkg::t_word v [8];
        sha224_pkg::t_word w;
        sha224_pkg::t_word t1;
        sha224_pkg::t_word t2;
        for (int i = 0; i < 8; i++) begin
            v[i] = chain_value[i];
        end
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w = sched[t];
            end else begin
                w = sched_mix1(sched[(t - 2) % 16]) + sched[(t - 7) % 16]
                  + sched_mix0(sched[(t - 15) % 16]) + sched[t % 16];
                sched[t % 16] = w;
            end
            t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
               + sha224_pkg::RoundK[t] + w;
            t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_value[i] = chain_value[i] + v[i];
        end
    endfunction

    // accepted input transaction
    function void absorb_word(input sha224_pkg::t_word word, input bit start, input bit fin);
        t_digest_rec rec;
        if (start) begin
            for (int i = 0; i < 8; i++) begin
                chain_value[i] = sha224_pkg::HashInit[i];
            end
            words_in_block = 0;
            final_seen = 1'b0;
        end
        sched[words_in_block] = word;
        if (fin) begin
            final_seen = 1'b1;
        end
        if (words_in_block < 15) begin
            words_in_block++;
            return;
        end
        words_in_block = 0;
        compress();
        if (!final_seen) begin
            return;
        end
        final_seen = 1'b0;
        digests_predicted++;
        for (int i = 0; i < 7; i++) begin
            rec.word = chain_value[i];
            rec.index = 3'(i);
            rec.last = (i == 6);
            expected_digest.push_back(rec);
        end
    endfunction

    task report(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        errors++;
    endtask

    // accepted digest transaction
    task check_digest(input sha224_pkg::t_word word, input logic [2:0] index, input logic last);
        t_digest_rec exp_rec;
        checked++;
        if (expected_digest.size() == 0) begin
            report($sformatf("unexpected digest word %h index %0d", word, index));
            return;
        end
        exp_rec = expected_digest.pop_front();
        if (word !== exp_rec.word) begin
            report($sformatf("digest word %0d: got %h want %h", exp_rec.index, word,
                             exp_rec.word));
        end
        if (index !== exp_rec.index) begin
            report($sformatf("digest index: got %0d want %0d", index, exp_rec.index));
        end
        if (last !== exp_rec.last) begin
            report($sformatf("last flag at index %0d: got %b want %b", exp_rec.index, last,
                             exp_rec.last));
        end
    endtask

    task drain_check();
        if (expected_digest.size() != 0) begin
            report($sformatf("%0d digest words never arrived", expected_digest.size()));
        end
    endtask
endclass

module sha224_block_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sha224_pkg::*;

    localparam int TOTAL_ITEMS = 430;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic        i_start_message = 1'b0;
    logic        i_final_block = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_last_digest_word;

    sha224_digest_model model;
    int words_sent = 0;
    int cycle_count = 0;
    bit hold_done = 1'b0;

    sha224_block_hash DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_message_word     (i_message_word),
        .i_start_message    (i_start_message),
        .i_final_block      (i_final_block),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_digest_word      (o_digest_word),
        .o_digest_index     (o_digest_index),
        .o_last_digest_word (o_last_digest_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            model.check_digest(o_digest_word, o_digest_index, o_last_digest_word);
        end
    end

    // receiver: random stall runs, one long hold once digests are flowing
    initial begin
        int r;
        int len;
        bit val;
        wait (i_rst_n);
        forever begin
            if (!hold_done && model.checked >= 14) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    val = 1'b0;
                    len = $urandom_range(1, 12);
                end else if (r < 85) begin
                    val = 1'b1;
                    len = $urandom_range(1, 3);
                end else if (r < 95) begin
                    val = 1'b0;
                    len = $urandom_range(20, 60);
                end else begin
                    val = 1'b1;
                    len = $urandom_range(15, 50);
                end
                repeat (len) begin
                    @(negedge i_clk);
                    i_stall <= val;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'h0000_0000;
        end else if (r == 1) begin
            return 32'hFFFF_FFFF;
        end else if (r == 2) begin
            return 32'h1 << $urandom_range(0, 31);
        end
        return $urandom;
    endfunction

    task automatic send_word(input t_word word, input bit start, input bit fin, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_message_word <= word;
        i_start_message <= start;
        i_final_block <= fin;
        do @(posedge i_clk); while (o_stall);
        model.absorb_word(word, start, fin);
        words_sent++;
    endtask

    // one message: mostly well formed, some chained without start,
    // some cut short, a few with no final block
    task automatic run_message();
        int kind;
        int nblocks;
        int cut;
        int fin_pos;
        bit with_start;
        bit no_final;
        bit burst;
        bit multi;
        bit start;
        bit fin;
        kind = $urandom_range(0, 99);
        with_start = (kind >= 12);
        nblocks = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 3);
        cut = (kind >= 12 && kind < 24) ? $urandom_range(1, 15) : 16;
        no_final = ($urandom_range(0, 19) == 0);
        burst = ($urandom_range(0, 5) == 0);
        for (int b = 0; b < nblocks; b++) begin
            fin_pos = ($urandom_range(0, 9) < 8) ? 15 : $urandom_range(0, 15);
            multi = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < 16; i++) begin
                if (b == nblocks - 1 && i == cut) begin
                    return;
                end
                start = with_start && b == 0 && i == 0;
                fin = !no_final && b == nblocks - 1
                    && (i == fin_pos || (multi && $urandom_range(0, 3) == 0));
                send_word(rand_word(), start, fin, burst ? 0 : pick_gap());
            end
        end
    endtask

    initial begin
        model = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray words, one flagged final, then a start in mid block
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1, 0);
        send_word(32'h0000_0000, 1'b0, 1'b0, 0);
        send_word(32'h8000_0000, 1'b0, 1'b0, 1);
        send_word(32'h0000_0001, 1'b0, 1'b0, 0);
        // extremes block, final flag on a middle word only
        for (int i = 0; i < 16; i++) begin
            send_word((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0, i == 7,
                      (i == 9) ? 2 : 0);
        end

        while (words_sent < TOTAL_ITEMS) begin
            run_message();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (model.expected_digest.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        model.drain_check();

        $display("Sent %0d message words; %0d digests predicted, %0d digest words checked.",
                 words_sent, model.digests_predicted, model.checked);
        $display("Long receiver hold-off %s; mismatches: %0d.",
                 hold_done ? "exercised" : "not reached", model.errors);
        if (model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
